### design/subarray_minimum_sum_macros.svh
// Assertion macros for the subarray minimum sum checker.
// Needs signals named clk and arst_n in the scope where a macro is used.
`ifndef SUBARRAY_MINIMUM_SUM_MACROS_SVH
`define SUBARRAY_MINIMUM_SUM_MACROS_SVH

// Checked at every edge outside reset.
`define SSM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SSM_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/ssm_pkg.sv
// Shared constants and types of the subarray minimum sum block.
// No dependencies.
package ssm_pkg;

	localparam int VALUE_BITS  = 16;
	localparam int TOTAL_BITS  = 30;
	localparam int DEF_MAX_LEN = 1024;

	localparam logic [TOTAL_BITS-1:0] MODULUS = 30'd1000000007;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_LOAD,
		ST_MUL,
		ST_RED,
		ST_SUM,
		ST_FIN
	} ssm_state_t;

endpackage

### design/ssm_if.sv
// Handshake channels of the subarray minimum sum block: input and result words.
// Depends on ssm_pkg for the payload widths.
interface ssm_in_if import ssm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value;
	logic                  last;

	modport source (output valid, value, last, input ready);
	modport sink (input valid, value, last, output ready);
endinterface

interface ssm_out_if import ssm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [TOTAL_BITS-1:0] total;
	logic                  overflow;

	modport source (output valid, total, overflow, input ready);
	modport sink (input valid, total, overflow, output ready);
endinterface

### design/subarray_minimum_sum.sv
// Subarray minimum sum: streams values in and gives one total per sequence.
// Depends on ssm_pkg and the channel interfaces in ssm_if.sv.
//
// The items channel takes one word per element: value and a last flag that
// closes the sequence. After the word with last set, the results channel
// gives one word: the sum over all contiguous subarrays of their minimum,
// modulo 1000000007, and an overflow flag if more than MAX_LEN elements came.
// Elements beyond MAX_LEN are dropped and only raise the flag.
// An accepted element passes the compare, multiply, reduction and sum steps
// and a final step before the next can be taken. Every entry popped off the
// monotonic stack while another entry stays below it adds a load step and a
// new compare (popping the last entry adds nothing); there are no reduction
// steps at MAX_LEN up to 8191. Pops are at most one per push on average. Each
// pop with an entry below waits on a registered read of the stack memory.
// Dropped elements go straight to the final step, which also registers the
// result after the last word, whether taken or dropped.
// The result sits in an output register: while the receiver stalls, the next
// sequence is taken in, and only its own last element waits in its final step.
// Reset empties the stack and clears the total; the stack memory is not cleared,
// since only entries pushed in the current sequence are ever read.
module subarray_minimum_sum import ssm_pkg::*; #(
	parameter int MAX_LEN = DEF_MAX_LEN
) (
	input  logic        clk,
	input  logic        arst_n,
	ssm_in_if.sink      items,
	ssm_out_if.source   results
);

	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int PROD_W  = CNT_W + VALUE_BITS;
	localparam int RED_K   = (PROD_W > 29) ? PROD_W - 29 : 0;
	localparam int RED_K1  = (RED_K > 0) ? RED_K - 1 : 0;
	localparam int RED_W   = (RED_K > 2) ? $clog2(RED_K) : 1;
	localparam int ENT_W   = VALUE_BITS + IDX_W + TOTAL_BITS;
	localparam logic [PROD_W-1:0] MOD_TOP = PROD_W'(64'(MODULUS) << RED_K1);

	ssm_state_t state_q, state_d;

	logic [CNT_W-1:0]      fill_q, fill_d;
	logic [CNT_W-1:0]      count_q, count_d;
	logic [TOTAL_BITS-1:0] total_q, total_d;
	logic                  ovf_q, ovf_d;
	logic                  out_valid_q, out_valid_d;

	logic [VALUE_BITS-1:0] val_q, val_d;
	logic                  last_q, last_d;
	logic [PROD_W-1:0]     prod_q, prod_d;
	logic [PROD_W-1:0]     msh_q, msh_d;
	logic [RED_W-1:0]      red_q, red_d;
	logic [TOTAL_BITS-1:0] dp_q, dp_d;
	logic [TOTAL_BITS-1:0] out_total_q, out_total_d;
	logic                  out_ovf_q, out_ovf_d;

	logic [VALUE_BITS-1:0] top_val_q;
	logic [IDX_W-1:0]      top_idx_q;
	logic [TOTAL_BITS-1:0] top_sum_q;

	logic [ENT_W-1:0] stack_mem [MAX_LEN];
	logic [ENT_W-1:0] rd_q;
	logic             mem_we;
	logic             rd_en;
	logic             top_ld;
	logic [IDX_W-1:0] wr_addr;
	logic [IDX_W-1:0] rd_addr;
	logic [ENT_W-1:0] wr_data;

	logic [CNT_W-1:0]      span;
	logic [TOTAL_BITS-1:0] prod_lo;
	logic [TOTAL_BITS-1:0] base;
	logic [TOTAL_BITS:0]   psum;
	logic [TOTAL_BITS-1:0] dp_new;
	logic [TOTAL_BITS:0]   acc;
	logic [TOTAL_BITS-1:0] acc_mod;

	assign items.ready      = (state_q == ST_IDLE);
	assign results.valid    = out_valid_q;
	assign results.total    = out_total_q;
	assign results.overflow = out_ovf_q;

	assign span    = (fill_q == '0) ? count_q + CNT_W'(1) : count_q - CNT_W'(top_idx_q);
	assign prod_lo = TOTAL_BITS'(prod_q);
	assign base    = (fill_q == '0) ? '0 : top_sum_q;
	assign psum    = {1'b0, base} + {1'b0, prod_lo};
	assign dp_new  = (psum >= {1'b0, MODULUS}) ? TOTAL_BITS'(psum - {1'b0, MODULUS})
		: TOTAL_BITS'(psum);
	assign acc     = {1'b0, total_q} + {1'b0, dp_q};
	assign acc_mod = (acc >= {1'b0, MODULUS}) ? TOTAL_BITS'(acc - {1'b0, MODULUS})
		: TOTAL_BITS'(acc);

	assign wr_addr = fill_q[IDX_W-1:0];
	assign rd_addr = IDX_W'(fill_q - CNT_W'(2));
	assign wr_data = {val_q, IDX_W'(count_q), dp_new};

	always_comb begin
		state_d     = state_q;
		fill_d      = fill_q;
		count_d     = count_q;
		total_d     = total_q;
		ovf_d       = ovf_q;
		out_valid_d = out_valid_q && !results.ready;
		out_total_d = out_total_q;
		out_ovf_d   = out_ovf_q;
		val_d       = val_q;
		last_d      = last_q;
		prod_d      = prod_q;
		msh_d       = msh_q;
		red_d       = red_q;
		dp_d        = dp_q;
		mem_we      = 1'b0;
		rd_en       = 1'b0;
		top_ld      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (items.valid) begin
					val_d  = items.value;
					last_d = items.last;
					if (count_q < CNT_W'(MAX_LEN)) begin
						state_d = ST_CMP;
					end else begin
						ovf_d   = 1'b1;
						dp_d    = '0;
						state_d = ST_FIN;
					end
				end
			end
			ST_CMP: begin
				if (fill_q != '0 && top_val_q > val_q) begin
					fill_d = fill_q - CNT_W'(1);
					if (fill_q > CNT_W'(1)) begin
						rd_en   = 1'b1;
						state_d = ST_LOAD;
					end else begin
						state_d = ST_MUL;
					end
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_LOAD: begin
				top_ld  = 1'b1;
				state_d = ST_CMP;
			end
			ST_MUL: begin
				prod_d  = PROD_W'(span) * PROD_W'(val_q);
				msh_d   = MOD_TOP;
				red_d   = RED_W'(RED_K1);
				state_d = (RED_K > 0) ? ST_RED : ST_SUM;
			end
			ST_RED: begin
				if (prod_q >= msh_q) begin
					prod_d = prod_q - msh_q;
				end
				msh_d = msh_q >> 1;
				if (red_q == '0) begin
					state_d = ST_SUM;
				end else begin
					red_d = red_q - RED_W'(1);
				end
			end
			ST_SUM: begin
				mem_we  = 1'b1;
				dp_d    = dp_new;
				fill_d  = fill_q + CNT_W'(1);
				count_d = count_q + CNT_W'(1);
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!last_q) begin
					total_d = acc_mod;
					state_d = ST_IDLE;
				end else if (!out_valid_q || results.ready) begin
					out_valid_d = 1'b1;
					out_total_d = acc_mod;
					out_ovf_d   = ovf_q;
					fill_d      = '0;
					count_d     = '0;
					total_d     = '0;
					ovf_d       = 1'b0;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			count_q     <= '0;
			total_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			fill_q      <= fill_d;
			count_q     <= count_d;
			total_q     <= total_d;
			ovf_q       <= ovf_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		val_q       <= val_d;
		last_q      <= last_d;
		prod_q      <= prod_d;
		msh_q       <= msh_d;
		red_q       <= red_d;
		dp_q        <= dp_d;
		out_total_q <= out_total_d;
		out_ovf_q   <= out_ovf_d;
		if (top_ld) begin
			top_val_q <= rd_q[ENT_W-1 -: VALUE_BITS];
			top_idx_q <= rd_q[TOTAL_BITS +: IDX_W];
			top_sum_q <= rd_q[TOTAL_BITS-1:0];
		end else if (mem_we) begin
			top_val_q <= val_q;
			top_idx_q <= IDX_W'(count_q);
			top_sum_q <= dp_new;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= stack_mem[rd_addr];
		end
	end

endmodule

### design/ssm_checker.sv
// Port-level checks of the subarray minimum sum block, bound to its top level.
// Depends on ssm_pkg and subarray_minimum_sum_macros.svh.
`include "subarray_minimum_sum_macros.svh"

module ssm_checker import ssm_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  items_valid,
	input logic                  items_ready,
	input logic                  results_valid,
	input logic                  results_ready,
	input logic [TOTAL_BITS-1:0] total,
	input logic                  overflow
);

	`SSM_ASSERT(a_result_held, results_valid && !results_ready |=> results_valid, "result word dropped while stalled")
	`SSM_ASSERT(a_result_stable, results_valid && !results_ready |=> $stable(total) && $stable(overflow), "result word changed while stalled")
	`SSM_ASSERT(a_total_reduced, results_valid |-> total < MODULUS, "total not reduced below the modulus")
	`SSM_ASSERT(a_busy_after_accept, items_valid && items_ready |=> !items_ready, "input word taken while the previous one is in work")
	`SSM_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !results_valid, "result word shown during reset")

endmodule

bind subarray_minimum_sum ssm_checker u_ssm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.items_valid   (items.valid),
	.items_ready   (items.ready),
	.results_valid (results.valid),
	.results_ready (results.ready),
	.total         (results.total),
	.overflow      (results.overflow)
);
